// File: sv/qmd_pkg.sv
// Shared types and constants for the queue with middle delete.
package qmd_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int VAL_W    = 32;
    localparam int EA_W     = 5;

    typedef enum logic [1:0] {
        ACT_PUSH     = 2'd0,
        ACT_POP      = 2'd1,
        ACT_READ_MID = 2'd2,
        ACT_DEL_MID  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_action                   action;
        logic signed [VAL_W-1:0]   push_value;
    } t_in_word;

    typedef struct packed {
        logic signed [VAL_W-1:0]   result_value;
        t_status                   status;
        logic [EA_W-1:0]           entries_after;
    } t_out_word;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [IDX_W-1:0] t_idx;

    localparam logic signed [VAL_W-1:0] EMPTY_VALUE = -32'sd1;

endpackage

// File: sv/qmd_in_reg.sv
// Input register stage: holds one request word until the store takes it.
module qmd_in_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  qmd_pkg::t_in_word i_word,
    input  logic             i_take,
    output logic             o_valid,
    output qmd_pkg::t_in_word o_word
);
    import qmd_pkg::*;

    logic     r_vld;
    t_in_word r_word;
    logic     w_load;

    // load when empty or when the held word is taken this cycle
    assign w_load = i_valid && (!r_vld || i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_vld;
    assign o_word  = r_word;

endmodule

// File: sv/qmd_store.sv
// Entry cells and fill count; works out one request's result and next state.
module qmd_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  qmd_pkg::t_in_word i_word,
    output qmd_pkg::t_out_word o_res
);
    import qmd_pkg::*;

    logic signed [VAL_W-1:0] r_cell [CAPACITY];
    logic signed [VAL_W-1:0] n_cell [CAPACITY];
    t_cnt                    r_count;
    t_cnt                    n_count;
    t_idx                    w_mid;
    t_idx                    w_tail;
    logic                    w_empty;
    logic                    w_full;

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == t_cnt'(CAPACITY));
    // lower middle: (count-1)/2
    assign w_mid   = IDX_W'((r_count - t_cnt'(1)) >> 1);
    assign w_tail  = IDX_W'(r_count);

    // per-cell next value: write at tail, or shift toward head
    always_comb begin
        n_cell  = r_cell;
        n_count = r_count;
        case (i_word.action)
            ACT_PUSH: begin
                if (!w_full) begin
                    n_cell[w_tail] = i_word.push_value;
                    n_count        = r_count + t_cnt'(1);
                end
            end
            ACT_POP: begin
                if (!w_empty) begin
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        n_cell[i] = r_cell[i+1];
                    end
                    n_count = r_count - t_cnt'(1);
                end
            end
            ACT_DEL_MID: begin
                if (!w_empty) begin
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (IDX_W'(i) >= w_mid) begin
                            n_cell[i] = r_cell[i+1];
                        end
                    end
                    n_count = r_count - t_cnt'(1);
                end
            end
            default: ;
        endcase
    end

    // result word
    always_comb begin
        o_res.result_value  = '0;
        o_res.status        = ST_OK;
        o_res.entries_after = EA_W'(32'(n_count));
        case (i_word.action)
            ACT_PUSH: begin
                if (w_full) begin
                    o_res.status = ST_FULL;
                end
            end
            ACT_POP: begin
                o_res.result_value = r_cell[0];
            end
            ACT_READ_MID, ACT_DEL_MID: begin
                o_res.result_value = r_cell[w_mid];
            end
            default: ;
        endcase
        if (i_word.action != ACT_PUSH && w_empty) begin
            o_res.result_value = EMPTY_VALUE;
            o_res.status       = ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_en) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

endmodule

// File: sv/queue_with_middle_delete_core.sv
// Queue with middle delete: input register, entry cells and result register.
// A request word passes through the input register and then the result register before its result word is presented.
// Throughput: one request word per cycle while the output is not stalled; every cell shifts or loads in parallel.
// The input register and result register decouple the two sides under stall.
// Reset (synchronous, active low) empties the queue; cell contents stay undefined.
module queue_with_middle_delete_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  qmd_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output qmd_pkg::t_out_word o_out_word
);
    import qmd_pkg::*;

    logic      w_req_vld;
    t_in_word  w_req;
    t_out_word w_res;
    logic      w_proc;
    logic      r_out_vld;
    t_out_word r_out_word;

    // a held request is processed when the result register can take it
    assign w_proc     = w_req_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = w_req_vld && !w_proc;

    qmd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .i_take  (w_proc),
        .o_valid (w_req_vld),
        .o_word  (w_req)
    );

    qmd_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_proc),
        .i_word  (w_req),
        .o_res   (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_proc) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out_word <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule
